[design/lcg48_pkg.sv]
// Package for the 48-bit LCG random generator core.
// Holds widths, constants, request codes, sequencer states and the MAC control struct.
// No dependencies.
`default_nettype none

package lcg48_pkg;

   localparam int STATE_W = 48;
   localparam int MULT_W  = 35;
   localparam int VALUE_W = 32;
   localparam int DRAW_W  = 31;
   localparam int FRAC_W  = 24;
   localparam int CHUNK_W = 16;
   localparam int PROD_W  = CHUNK_W + MULT_W;
   localparam int ACC_W   = 64;
   localparam int NBITS_W = 6;
   localparam int CNT_W   = 5;

   localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
   localparam logic [STATE_W-1:0] LCG_INC  = 48'h0000_0000_000B;

   // step counts of the sequencer
   localparam logic [CNT_W-1:0] LCG_LAST_CHUNK  = 5'd2;
   localparam logic [CNT_W-1:0] POW2_LAST_CHUNK = 5'd1;
   localparam logic [CNT_W-1:0] DIV_LAST_STEP   = 5'(DRAW_W - 1);

   // request function codes
   localparam logic [1:0] FUNC_RAW     = 2'd0;
   localparam logic [1:0] FUNC_BOUNDED = 2'd1;
   localparam logic [1:0] FUNC_RANGE   = 2'd2;
   localparam logic [1:0] FUNC_FRAC    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SEL,
      ST_PMUL,
      ST_PWAIT,
      ST_PFIN,
      ST_DIV,
      ST_CHECK,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic       step;
      logic       first;
      logic [1:0] idx;
   } mac_ctrl_type;

endpackage

`default_nettype wire

[design/lcg48_if.sv]
// Handshake interfaces of the LCG random generator core: request, response, seed write.
// Depends on lcg48_pkg for field widths.
`default_nettype none

interface lcg48_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic [lcg48_pkg::NBITS_W-1:0]     bit_count;
   logic signed [lcg48_pkg::VALUE_W-1:0] bound;
   logic signed [lcg48_pkg::VALUE_W-1:0] lower;
   logic signed [lcg48_pkg::VALUE_W-1:0] upper;

   modport source (output valid, func, bit_count, bound, lower, upper, input ready);
   modport sink   (input valid, func, bit_count, bound, lower, upper, output ready);
endinterface

interface lcg48_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lcg48_pkg::VALUE_W-1:0] value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

interface lcg48_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lcg48_pkg::STATE_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[design/lcg48_mac.sv]
// Shared multiply-accumulate unit: 16-bit chunk times 35-bit operand, shifted into a
// 64-bit accumulator. Depends on lcg48_pkg.
`default_nettype none

module lcg48_mac (
   input  wire                             clock,
   input  lcg48_pkg::mac_ctrl_type         ctrl,
   input  wire [lcg48_pkg::CHUNK_W-1:0]    a_chunk,
   input  wire [lcg48_pkg::MULT_W-1:0]     b_word,
   output logic [lcg48_pkg::ACC_W-1:0]     acc
);
   import lcg48_pkg::*;

   logic [PROD_W-1:0] prod;
   logic [ACC_W-1:0]  prod_shifted;
   logic [5:0]        shift_amt;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;

   // form one partial product and place it at its chunk weight
   always_comb begin
      prod         = PROD_W'(a_chunk) * PROD_W'(b_word);
      shift_amt    = {ctrl.idx, 4'b0000};
      prod_shifted = ACC_W'(prod) << shift_amt;
      acc_in       = acc_ff;
      if (ctrl.step) begin
         acc_in = ctrl.first ? prod_shifted : acc_ff + prod_shifted;
      end
   end

   // hold the running sum
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

[design/lcg48_random_generator_core.sv]
// 48-bit LCG random generator core (multiply by 0x5DEECE66D, add 11, mod 2^48).
// One state advance runs on the shared 16x35 MAC (3 chunks, add, select).
// Raw and fraction requests: advance, then response. Bounded power-of-two: advance, multiply by n.
// Other bounds: per draw an advance, a 31-step remainder and a check, repeated on rejection.
// Non-positive bound: answers with the offset, state kept. One request at a time, next taken after the response.
// Reset (synchronous, active high) loads the state with 0x5DEECE66D.
`default_nettype none

module lcg48_random_generator_core (
   input  wire         clock,
   input  wire         reset,
   lcg48_req_if.sink   req_bus,
   lcg48_rsp_if.source rsp_bus,
   lcg48_csr_if.sink   csr_bus
);
   import lcg48_pkg::*;

   seq_state_type      seq_ff, seq_in;
   logic [STATE_W-1:0] lcg_state_ff, lcg_state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         func_ff, func_in;
   logic [NBITS_W-1:0] nbits_ff, nbits_in;
   logic [VALUE_W-1:0] n_ff, n_in;
   logic [VALUE_W-1:0] offset_ff, offset_in;
   logic               pow2_ff, pow2_in;
   logic [STATE_W-1:0] mul_a_ff, mul_a_in;
   logic [DRAW_W-1:0]  draw_ff, draw_in;
   logic [DRAW_W-1:0]  div_d_ff, div_d_in;
   logic [DRAW_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   mac_ctrl_type       mac_ctrl;
   logic [CHUNK_W-1:0] mac_a;
   logic [MULT_W-1:0]  mac_b;
   logic [ACC_W-1:0]   mac_acc;

   logic [VALUE_W-1:0] req_n;
   logic [VALUE_W-1:0] req_offset;
   logic [NBITS_W-1:0] raw_shift;
   logic [STATE_W-1:0] raw_bits;
   logic [VALUE_W-1:0] div_trial;
   logic               div_ge;
   logic [VALUE_W-1:0] check_sum;

   lcg48_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .a_chunk (mac_a),
      .b_word  (mac_b),
      .acc     (mac_acc)
   );

   // sequencer: next state, datapath selects and handshakes
   always_comb begin
      seq_in       = seq_ff;
      lcg_state_in = lcg_state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      nbits_in     = nbits_ff;
      n_in         = n_ff;
      offset_in    = offset_ff;
      pow2_in      = pow2_ff;
      mul_a_in     = mul_a_ff;
      draw_in      = draw_ff;
      div_d_in     = div_d_ff;
      rem_in       = rem_ff;
      value_in     = value_ff;

      mac_ctrl.step  = 1'b0;
      mac_ctrl.first = (cnt_ff == '0);
      mac_ctrl.idx   = cnt_ff[1:0];
      mac_a          = mul_a_ff[{cnt_ff[1:0], 4'b0000} +: CHUNK_W];
      mac_b          = (seq_ff == ST_PMUL) ? MULT_W'(n_ff) : LCG_MULT[MULT_W-1:0];

      req_bus.ready = (seq_ff == ST_IDLE);
      rsp_bus.valid = (seq_ff == ST_OUT);
      csr_bus.ready = 1'b1;

      // request decode: range mode works on upper - lower and adds lower back
      req_n      = (req_bus.func == FUNC_RANGE) ? req_bus.upper - req_bus.lower : req_bus.bound;
      req_offset = (req_bus.func == FUNC_RANGE) ? req_bus.lower : '0;

      raw_shift = NBITS_W'(STATE_W) - nbits_ff;
      raw_bits  = lcg_state_ff >> raw_shift;

      div_trial = {rem_ff, div_d_ff[DRAW_W-1]};
      div_ge    = (div_trial >= n_ff);

      check_sum = VALUE_W'(draw_ff) - VALUE_W'(rem_ff) + (n_ff - 1'b1);

      case (seq_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               func_in   = req_bus.func;
               nbits_in  = (req_bus.bit_count > NBITS_W'(VALUE_W)) ? NBITS_W'(VALUE_W)
                                                                   : req_bus.bit_count;
               n_in      = req_n;
               offset_in = req_offset;
               pow2_in   = ((req_n & (req_n - 1'b1)) == '0);
               mul_a_in  = lcg_state_ff;
               cnt_in    = '0;
               if ((req_bus.func == FUNC_BOUNDED || req_bus.func == FUNC_RANGE) &&
                   (req_n[VALUE_W-1] || req_n == '0)) begin
                  // non-positive bound: answer with the offset, keep the state
                  value_in = req_offset;
                  seq_in   = ST_OUT;
               end else begin
                  seq_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            mac_ctrl.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == LCG_LAST_CHUNK) begin
               seq_in = ST_ADD;
            end
         end
         ST_ADD: begin
            lcg_state_in = mac_acc[STATE_W-1:0] + LCG_INC;
            seq_in       = ST_SEL;
         end
         ST_SEL: begin
            draw_in  = lcg_state_ff[STATE_W-1 -: DRAW_W];
            div_d_in = lcg_state_ff[STATE_W-1 -: DRAW_W];
            mul_a_in = STATE_W'(lcg_state_ff[STATE_W-1 -: DRAW_W]);
            rem_in   = '0;
            cnt_in   = '0;
            case (func_ff)
               FUNC_RAW: begin
                  value_in = raw_bits[VALUE_W-1:0];
                  seq_in   = ST_OUT;
               end
               FUNC_FRAC: begin
                  value_in = VALUE_W'(lcg_state_ff[STATE_W-1 -: FRAC_W]);
                  seq_in   = ST_OUT;
               end
               default: begin
                  seq_in = pow2_ff ? ST_PMUL : ST_DIV;
               end
            endcase
         end
         ST_PMUL: begin
            mac_ctrl.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == POW2_LAST_CHUNK) begin
               seq_in = ST_PWAIT;
            end
         end
         ST_PWAIT: begin
            seq_in = ST_PFIN;
         end
         ST_PFIN: begin
            value_in = VALUE_W'(mac_acc[DRAW_W +: DRAW_W]) + offset_ff;
            seq_in   = ST_OUT;
         end
         ST_DIV: begin
            // one restoring remainder step per cycle, dividend bits MSB first
            rem_in   = div_ge ? DRAW_W'(div_trial - n_ff) : DRAW_W'(div_trial);
            div_d_in = div_d_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST_STEP) begin
               seq_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (check_sum[VALUE_W-1]) begin
               // reject the draw and advance again
               mul_a_in = lcg_state_ff;
               cnt_in   = '0;
               seq_in   = ST_MUL;
            end else begin
               value_in = VALUE_W'(rem_ff) + offset_ff;
               seq_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               seq_in = ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase

      // seed write reloads the state
      if (csr_bus.valid) begin
         lcg_state_in = csr_bus.data ^ LCG_MULT;
      end
   end

   assign rsp_bus.value = value_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         lcg_state_ff <= LCG_MULT;
      end else begin
         seq_ff       <= seq_in;
         lcg_state_ff <= lcg_state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      func_ff   <= func_in;
      nbits_ff  <= nbits_in;
      n_ff      <= n_in;
      offset_ff <= offset_in;
      pow2_ff   <= pow2_in;
      mul_a_ff  <= mul_a_in;
      draw_ff   <= draw_in;
      div_d_ff  <= div_d_in;
      rem_ff    <= rem_in;
      value_ff  <= value_in;
   end

endmodule

`default_nettype wire
